// ===== sv/hhfe_pkg.sv =====
package hhfe_pkg;

    // Largest header name that is compared, in bytes
    localparam int NAME_MAX_BYTES  = 16;
    // Largest value that is copied, in bytes
    localparam int VALUE_MAX_BYTES = 1023;

    localparam logic [4:0] NAME_CAP  = 5'(NAME_MAX_BYTES);
    localparam logic [9:0] LIMIT_CAP = 10'(VALUE_MAX_BYTES);

    // Lookup status codes, valid when done_res is set
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_COLON  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] status;
        logic [9:0] value_length;
    } result_item_t;

    typedef struct packed {
        logic [63:0] name_bytes_low;
        logic [63:0] name_bytes_high;
        logic [4:0]  name_length;
        logic [9:0]  copy_limit;
        logic        accept_bare_lf;
    } cfg_t;

endpackage

// ===== sv/http_header_field_extractor.sv =====
// Streaming header field lookup. Header text enters one byte per transaction on the text
// channel, with last marking the final byte of a header block; a NUL byte also ends the
// text. The block finds the first line that begins with the configured name (prefix
// match), moves to the next colon, skips linear white space including folded lines, and
// then returns one result transaction per copied value byte, the final one carrying
// done_res with the status and, when found, the value length. At most one result leaves
// for each byte. Throughput is one byte per clock unless a stalled result blocks the
// output: the phase, match position and copy count are updated combinationally between
// the input register and the result register, and that state update sets the rate. A
// byte's result is made from the input register and held in the result register. Write
// configuration only while no lookup is in flight; writes act from the next byte on.
module http_header_field_extractor
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   text_valid,
    output logic                   text_stall,
    input  hhfe_pkg::text_item_t   text,

    output logic                   result_valid,
    input  logic                   result_stall,
    output hhfe_pkg::result_item_t result,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);

    localparam logic [2:0] REG_NAME_LOW  = 3'd0;
    localparam logic [2:0] REG_NAME_HIGH = 3'd1;
    localparam logic [2:0] REG_NAME_LEN  = 3'd2;
    localparam logic [2:0] REG_LIMIT     = 3'd3;
    localparam logic [2:0] REG_BARE_LF   = 3'd4;

    hhfe_pkg::cfg_t         cfg_reg;
    hhfe_pkg::text_item_t   in_reg;
    logic                   in_valid_reg;
    hhfe_pkg::result_item_t out_reg;
    logic                   out_valid_reg;

    logic                   go;
    logic                   produce;
    logic                   out_free;
    logic                   text_take;
    hhfe_pkg::result_item_t step_result;

    // Configuration writes never wait
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_bytes_low  <= '0;
            cfg_reg.name_bytes_high <= '0;
            cfg_reg.name_length     <= 5'd1;
            cfg_reg.copy_limit      <= 10'd1023;
            cfg_reg.accept_bare_lf  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to indexes beyond the register list
            unique case (cfg_index)
                REG_NAME_LOW:  cfg_reg.name_bytes_low  <= cfg_data;
                REG_NAME_HIGH: cfg_reg.name_bytes_high <= cfg_data;
                REG_NAME_LEN:  cfg_reg.name_length     <= cfg_data[4:0];
                REG_LIMIT:     cfg_reg.copy_limit      <= cfg_data[9:0];
                REG_BARE_LF:   cfg_reg.accept_bare_lf  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance a held byte when its result, if any, has room in the output register
    assign out_free   = !out_valid_reg || !result_stall;
    assign go         = in_valid_reg && (!produce || out_free);
    assign text_stall = in_valid_reg && !go;
    assign text_take  = text_valid && !text_stall;

    hhfe_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .produce (produce),
        .result  (step_result)
    );

    // Input register: holds one byte awaiting its state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text_take)
            in_valid_reg <= 1'b1;
        else if (go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
            in_reg <= text;
    end

    // Result register: hold while stalled, load a new result when one is produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go && produce)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && produce)
            out_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_produce_lands: assert property (@(posedge clk) disable iff (!rst_n)
        go && produce |=> result_valid)
        else $error("produced result did not reach the output register");

    a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.done_res)
        else $error("result without a value byte is not a final result");

    a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.done_res |->
            result.status == hhfe_pkg::ST_FOUND && result.value_length == 10'd0)
        else $error("non-final result carries status or length");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> in_valid_reg && result_valid && result_stall)
        else $error("text stalled without a blocked result");

endmodule

// ===== sv/hhfe_engine.sv =====
module hhfe_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  hhfe_pkg::text_item_t  item,
    input  hhfe_pkg::cfg_t        cfg,
    output logic                  produce,
    output hhfe_pkg::result_item_t result
);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        PH_MATCH,
        PH_SKIP,
        PH_COLON,
        PH_LWS,
        PH_LWS_CR,
        PH_LWS_CRLF,
        PH_LWS_LF,
        PH_COPY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [9:0]  count_reg, count_next;

    logic [7:0]   b;
    logic         is_wsp;
    logic [127:0] name_word;
    logic [7:0]   name_byte;
    logic [4:0]   name_len_eff;
    logic [4:0]   pos_inc;
    logic [9:0]   limit;
    logic [9:0]   count_inc;
    logic         count_hit;
    logic         inc_hit;

    assign b            = item.text_byte;
    assign is_wsp       = (b == CH_SP) || (b == CH_TAB);
    assign name_word    = {cfg.name_bytes_high, cfg.name_bytes_low};
    assign name_byte    = name_word[{pos_reg, 3'b000} +: 8];
    assign name_len_eff = (cfg.name_length > hhfe_pkg::NAME_CAP) ? hhfe_pkg::NAME_CAP
                                                                  : cfg.name_length;
    assign pos_inc      = {1'b0, pos_reg} + 5'd1;
    assign limit        = (cfg.copy_limit > hhfe_pkg::LIMIT_CAP) ? hhfe_pkg::LIMIT_CAP
                                                                  : cfg.copy_limit;
    assign count_inc    = count_reg + 10'd1;
    assign count_hit    = (count_reg >= limit);
    assign inc_hit      = (count_inc >= limit);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        result     = '0;
        produce    = 1'b0;

        // an empty name matches right at the start of the text
        if (phase_next == PH_MATCH && name_len_eff == 5'd0)
        begin
            pos_next   = '0;
            phase_next = PH_COLON;
        end

        if (phase_next != PH_DONE && b != CH_NUL)
        begin
            unique case (phase_next)
                PH_MATCH:
                begin
                    if (b == name_byte)
                    begin
                        if (pos_inc >= name_len_eff)
                        begin
                            pos_next   = '0;
                            phase_next = PH_COLON;
                        end
                        else
                        begin
                            pos_next = pos_inc[3:0];
                        end
                    end
                    else
                    begin
                        pos_next   = '0;
                        phase_next = (b == CH_LF) ? PH_MATCH : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (b == CH_LF)
                        phase_next = PH_MATCH;
                end
                PH_COLON:
                begin
                    if (b == CH_COLON)
                        phase_next = PH_LWS;
                end
                PH_LWS, PH_COPY:
                begin
                    if (phase_next == PH_LWS && is_wsp)
                    begin
                        phase_next = PH_LWS;
                    end
                    else if (phase_next == PH_LWS && b == CH_CR)
                    begin
                        phase_next = PH_LWS_CR;
                    end
                    else if (phase_next == PH_LWS && b == CH_LF && cfg.accept_bare_lf)
                    begin
                        phase_next = PH_LWS_LF;
                    end
                    else if (b == CH_CR || b == CH_LF)
                    begin
                        // line ends: value complete (empty when still in white space)
                        produce             = 1'b1;
                        result.done_res     = 1'b1;
                        result.status       = hhfe_pkg::ST_FOUND;
                        result.value_length = (phase_next == PH_COPY) ? count_reg : 10'd0;
                        phase_next          = PH_DONE;
                    end
                    else
                    begin
                        // copy one value byte unless the limit is already reached
                        phase_next = PH_COPY;
                        produce    = 1'b1;
                        if (count_hit)
                        begin
                            result.done_res     = 1'b1;
                            result.status       = hhfe_pkg::ST_FOUND;
                            result.value_length = count_reg;
                            phase_next          = PH_DONE;
                        end
                        else
                        begin
                            result.value_byte = b;
                            result.byte_valid = 1'b1;
                            count_next        = count_inc;
                            if (inc_hit)
                            begin
                                result.done_res     = 1'b1;
                                result.status       = hhfe_pkg::ST_FOUND;
                                result.value_length = count_inc;
                                phase_next          = PH_DONE;
                            end
                        end
                    end
                end
                PH_LWS_CR:
                begin
                    if (b == CH_LF)
                    begin
                        phase_next = PH_LWS_CRLF;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = hhfe_pkg::ST_FOUND;
                        phase_next      = PH_DONE;
                    end
                end
                PH_LWS_CRLF, PH_LWS_LF:
                begin
                    if (is_wsp)
                    begin
                        phase_next = PH_LWS;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = hhfe_pkg::ST_FOUND;
                        phase_next      = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // end of text closes the lookup, keeping a byte copied in this step
        if (phase_next != PH_DONE && (b == CH_NUL || item.last))
        begin
            produce         = 1'b1;
            result.done_res = 1'b1;
            unique case (phase_next)
                PH_MATCH, PH_SKIP:
                    result.status = hhfe_pkg::ST_NOT_FOUND;
                PH_COLON:
                    result.status = hhfe_pkg::ST_NO_COLON;
                PH_COPY:
                begin
                    result.status       = hhfe_pkg::ST_FOUND;
                    result.value_length = count_next;
                end
                default:
                    result.status = hhfe_pkg::ST_FOUND;
            endcase
            phase_next = PH_DONE;
        end

        if (item.last)
        begin
            phase_next = PH_MATCH;
            pos_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MATCH;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== tb/http_header_field_extractor_checker.sv =====
`timescale 1ns / 100ps

module http_header_field_extractor_checker
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   text_valid,
    input  logic                   text_stall,
    input  hhfe_pkg::text_item_t   text,

    input  logic                   result_valid,
    input  logic                   result_stall,
    input  hhfe_pkg::result_item_t result,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,

    output int                     fail_count,
    output int                     pending,
    output int                     results_checked,
    output int                     lookups_found,
    output int                     lookups_missed
);

    localparam logic [2:0] REG_NAME_LOW   = 3'd0;
    localparam logic [2:0] REG_NAME_HIGH  = 3'd1;
    localparam logic [2:0] REG_NAME_LEN   = 3'd2;
    localparam logic [2:0] REG_COPY_LIMIT = 3'd3;
    localparam logic [2:0] REG_BARE_LF    = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        LK_MATCH,
        LK_SKIP,
        LK_COLON,
        LK_LWS,
        LK_LWS_CR,
        LK_LWS_CRLF,
        LK_LWS_LF,
        LK_COPY,
        LK_DONE
    } lookup_phase_t;

    // Shadow of the lookup state and of the registers
    lookup_phase_t lk_phase;
    logic [4:0]    match_pos;
    logic [9:0]    copied;
    logic [63:0]   name_lo;
    logic [63:0]   name_hi;
    logic [4:0]    name_len;
    logic [9:0]    copy_lim;
    logic          bare_lf;

    hhfe_pkg::result_item_t step_result;
    hhfe_pkg::result_item_t expected_q [$];

    function automatic logic [4:0] name_span();
        return (name_len > hhfe_pkg::NAME_CAP) ? hhfe_pkg::NAME_CAP : name_len;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB;
    endfunction

    function automatic void conclude(input logic [1:0] st, input logic [9:0] len);
        step_result.done_res     = 1'b1;
        step_result.status       = st;
        step_result.value_length = len;
        lk_phase                 = LK_DONE;
    endfunction

    function automatic void copy_value(input logic [7:0] b);
        logic [9:0] lim;
        lim      = (copy_lim > hhfe_pkg::LIMIT_CAP) ? hhfe_pkg::LIMIT_CAP : copy_lim;
        lk_phase = LK_COPY;
        if (copied >= lim) begin
            conclude(hhfe_pkg::ST_FOUND, copied);
        end
        else begin
            step_result.value_byte = b;
            step_result.byte_valid = 1'b1;
            copied                 = copied + 10'd1;
            if (copied >= lim)
                conclude(hhfe_pkg::ST_FOUND, copied);
        end
    endfunction

    // Advance the lookup by one text byte; returns one when a result leaves
    function automatic logic predict_text_byte(input hhfe_pkg::text_item_t item);
        logic [7:0]  b;
        logic [63:0] word;
        b           = item.text_byte;
        step_result = '0;
        if (lk_phase == LK_MATCH && name_span() == 5'd0) begin
            match_pos = '0;
            lk_phase  = LK_COLON;
        end
        if (lk_phase != LK_DONE && b != CH_NUL) begin
            case (lk_phase)
                LK_MATCH: begin
                    word = match_pos[3] ? name_hi : name_lo;
                    if (b == word[match_pos[2:0] * 8 +: 8]) begin
                        match_pos = match_pos + 5'd1;
                        if (match_pos >= name_span()) begin
                            match_pos = '0;
                            lk_phase  = LK_COLON;
                        end
                    end
                    else begin
                        match_pos = '0;
                        lk_phase  = (b == CH_LF) ? LK_MATCH : LK_SKIP;
                    end
                end
                LK_SKIP: begin
                    if (b == CH_LF)
                        lk_phase = LK_MATCH;
                end
                LK_COLON: begin
                    if (b == CH_COLON)
                        lk_phase = LK_LWS;
                end
                LK_LWS: begin
                    if (b == CH_CR)
                        lk_phase = LK_LWS_CR;
                    else if (b == CH_LF) begin
                        if (bare_lf)
                            lk_phase = LK_LWS_LF;
                        else
                            conclude(hhfe_pkg::ST_FOUND, '0);
                    end
                    else if (!is_blank(b))
                        copy_value(b);
                end
                LK_LWS_CR: begin
                    if (b == CH_LF)
                        lk_phase = LK_LWS_CRLF;
                    else
                        conclude(hhfe_pkg::ST_FOUND, '0);
                end
                LK_LWS_CRLF, LK_LWS_LF: begin
                    if (is_blank(b))
                        lk_phase = LK_LWS;
                    else
                        conclude(hhfe_pkg::ST_FOUND, '0);
                end
                LK_COPY: begin
                    if (b == CH_CR || b == CH_LF)
                        conclude(hhfe_pkg::ST_FOUND, copied);
                    else
                        copy_value(b);
                end
                default: ;
            endcase
        end
        // End of text closes the lookup, possibly in the same transaction as a byte
        if (lk_phase != LK_DONE && (b == CH_NUL || item.last)) begin
            case (lk_phase)
                LK_MATCH, LK_SKIP: conclude(hhfe_pkg::ST_NOT_FOUND, '0);
                LK_COLON:          conclude(hhfe_pkg::ST_NO_COLON, '0);
                LK_COPY:           conclude(hhfe_pkg::ST_FOUND, copied);
                default:           conclude(hhfe_pkg::ST_FOUND, '0);
            endcase
        end
        if (item.last) begin
            lk_phase  = LK_MATCH;
            match_pos = '0;
            copied    = '0;
        end
        return step_result.byte_valid | step_result.done_res;
    endfunction

    function automatic logic field_differs(input string fname, input logic [15:0] want,
                                           input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        hhfe_pkg::result_item_t want;
        logic                   bad;
        if (!rst_n) begin
            lk_phase  = LK_MATCH;
            match_pos = '0;
            copied    = '0;
            name_lo   = '0;
            name_hi   = '0;
            name_len  = 5'd1;
            copy_lim  = 10'd1023;
            bare_lf   = 1'b0;
            expected_q.delete();
            pending   = 0;
        end
        else begin
            // Compare before predicting: a result never belongs to a byte of this edge
            if (result_valid && !result_stall) begin
                results_checked++;
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected: %p", result);
                    fail_count++;
                end
                else begin
                    want = expected_q.pop_front();
                    bad  = field_differs("value_byte", 16'(want.value_byte),
                                         16'(result.value_byte))
                         | field_differs("byte_valid", 16'(want.byte_valid),
                                         16'(result.byte_valid))
                         | field_differs("done_res", 16'(want.done_res),
                                         16'(result.done_res))
                         | field_differs("status", 16'(want.status), 16'(result.status))
                         | field_differs("value_length", 16'(want.value_length),
                                         16'(result.value_length));
                    if (bad)
                        fail_count++;
                    if (want.done_res) begin
                        if (want.status == hhfe_pkg::ST_FOUND)
                            lookups_found++;
                        else
                            lookups_missed++;
                    end
                end
            end
            if (text_valid && !text_stall) begin
                if (predict_text_byte(text))
                    expected_q.push_back(step_result);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NAME_LOW:   name_lo  = cfg_data;
                    REG_NAME_HIGH:  name_hi  = cfg_data;
                    REG_NAME_LEN:   name_len = cfg_data[4:0];
                    REG_COPY_LIMIT: copy_lim = cfg_data[9:0];
                    REG_BARE_LF:    bare_lf  = cfg_data[0];
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/http_header_field_extractor_tb.sv =====
`timescale 1ns / 100ps

module http_header_field_extractor_tb;

    // Register map of the configuration port
    localparam logic [2:0] REG_NAME_LOW   = 3'd0;
    localparam logic [2:0] REG_NAME_HIGH  = 3'd1;
    localparam logic [2:0] REG_NAME_LEN   = 3'd2;
    localparam logic [2:0] REG_COPY_LIMIT = 3'd3;
    localparam logic [2:0] REG_BARE_LF    = 3'd4;

    // Characters with a meaning to the lookup
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Least number of header bytes sent under each random register setting
    localparam int BYTES_PER_SETTING = 64;

    // Every input starts at a known value; clk starts low without an edge at time zero
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   text_valid   = 1'b0;
    logic                   text_stall;
    hhfe_pkg::text_item_t   text         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    hhfe_pkg::result_item_t result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index    = '0;
    logic [63:0]            cfg_data     = '0;

    int           fail_count;
    int           pending;
    int           results_checked;
    int           lookups_found;
    int           lookups_missed;

    int unsigned  src_gap_pct   = 0;
    int unsigned  dst_stall_pct = 0;
    int           bytes_sent    = 0;
    int           settings_used = 0;

    // What the header generator knows about the current setting
    logic [7:0]   name_chars [16];
    int           name_used;
    logic [7:0]   hdr [$];

    http_header_field_extractor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text         (text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    http_header_field_extractor_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_stall      (text_stall),
        .text            (text),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .lookups_found   (lookups_found),
        .lookups_missed  (lookups_missed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure: redraw the stall on every falling edge
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    // Drive one register write and hold it until the port takes it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drain, then reprogram every register; name bytes sit in name_word, byte 0 lowest
    task automatic apply_settings(input logic [4:0] len, input logic [9:0] limit,
                                  input logic bare, input logic [127:0] name_word);
        @(negedge clk);
        text_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // A byte that produces no result may still be in the pipe: give it time
        repeat (6) @(negedge clk);
        write_reg(REG_NAME_LOW, name_word[63:0]);
        write_reg(REG_NAME_HIGH, name_word[127:64]);
        write_reg(REG_NAME_LEN, 64'(len));
        write_reg(REG_COPY_LIMIT, 64'(limit));
        write_reg(REG_BARE_LF, 64'(bare));
        @(negedge clk);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 16; i++)
            name_chars[i] = name_word[i * 8 +: 8];
        name_used = (len > 5'd16) ? 16 : int'(len);
        settings_used++;
    endtask

    // Send the queued header, last on its final byte; hold each transaction while stalled
    task automatic send_header();
        foreach (hdr[i]) begin
            @(negedge clk);
            while ($urandom_range(99) < src_gap_pct) begin
                text_valid <= 1'b0;
                @(negedge clk);
            end
            text_valid <= 1'b1;
            text       <= '{text_byte: hdr[i], last: (i == hdr.size() - 1)};
            @(posedge clk);
            while (text_stall)
                @(posedge clk);
            bytes_sent++;
        end
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(97, 122));
    endfunction

    // Any nonzero byte that does not break a line; optionally no colon either
    function automatic logic [7:0] rand_text_byte(input logic no_colon);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_CR || c == CH_LF || (no_colon && c == CH_COLON));
        return c;
    endfunction

    function automatic void add_name(input int n);
        for (int i = 0; i < n; i++)
            hdr.push_back(name_chars[i]);
    endfunction

    function automatic void add_eol();
        if ($urandom_range(3) != 0)
            hdr.push_back(CH_CR);
        hdr.push_back(CH_LF);
    endfunction

    // Linear white space, folded lines included
    function automatic void add_lws();
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(5))
                0: hdr.push_back(CH_SP);
                1: hdr.push_back(CH_TAB);
                2: begin hdr.push_back(CH_CR); hdr.push_back(CH_LF); hdr.push_back(CH_SP); end
                3: begin hdr.push_back(CH_CR); hdr.push_back(CH_LF); hdr.push_back(CH_TAB); end
                4: begin hdr.push_back(CH_LF); hdr.push_back(CH_SP); end
                default: begin hdr.push_back(CH_SP); hdr.push_back(CH_SP); end
            endcase
        end
    endfunction

    // Mostly short printable values, now and then long or binary
    function automatic void add_value();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
        repeat (n) begin
            if ($urandom_range(3) == 0)
                hdr.push_back(rand_text_byte(1'b0));
            else
                hdr.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    // A line that must not be taken for the wanted field
    function automatic void add_decoy();
        case ($urandom_range(3))
            0: begin
                repeat ($urandom_range(1, 6)) hdr.push_back(letter());
                hdr.push_back(CH_COLON);
                hdr.push_back(CH_SP);
                add_value();
            end
            1: begin
                // near miss: a proper prefix of the name, then something else
                if (name_used > 1)
                    add_name($urandom_range(1, name_used - 1));
                hdr.push_back(letter());
                hdr.push_back(CH_COLON);
                add_value();
            end
            2: begin
                // the name, but not at the start of the line
                hdr.push_back(CH_SP);
                add_name(name_used);
                hdr.push_back(CH_COLON);
                add_value();
            end
            default: begin
                repeat ($urandom_range(1, 10)) hdr.push_back(8'($urandom_range(32, 126)));
            end
        endcase
        add_eol();
    endfunction

    initial
    begin
        int             seg;
        int             span;
        int             phase_bytes;
        logic [4:0]     len;
        logic [9:0]     limit;
        logic [127:0]   name_word;
        logic           done_early;

        // Hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the first idling mix
        src_gap_pct   = 7;
        dst_stall_pct = 86;

        name_word = {$urandom(), $urandom(), $urandom(), $urandom()};
        name_word[7:0] = 8'h48;
        apply_settings(5'd1, 10'd1023, 1'b0, name_word);
        // value ends on the byte marked last: byte and done in one transaction
        hdr = '{8'h48, CH_COLON, CH_SP, 8'h61, 8'h62};
        send_header();
        // LF at a line start restarts the match, NUL ends the text, later bytes ignored
        hdr = '{CH_LF, 8'h48, CH_NUL, 8'h7A};
        send_header();
        // folded CR LF TAB before the value, CR ends it, bytes after done ignored
        hdr = '{8'h48, CH_COLON, CH_CR, CH_LF, CH_TAB, 8'h71, CH_CR, 8'h5A};
        send_header();
        // all-ones byte, alone and last
        hdr = '{8'hFF};
        send_header();

        // empty name matches at the start, bare LF fold, zero copy limit
        name_word = {$urandom(), $urandom(), $urandom(), $urandom()};
        apply_settings(5'd0, 10'd0, 1'b1, name_word);
        hdr = '{CH_COLON, CH_LF, CH_SP, 8'h76};
        send_header();

        // Random part: three idling mixes, three register settings each
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin src_gap_pct = 7;  dst_stall_pct = 86; end
                1: begin src_gap_pct = 86; dst_stall_pct = 7;  end
                default: begin src_gap_pct = 0; dst_stall_pct = 0; end
            endcase
            for (int k = 0; k < 3; k++) begin
                if (k == 0) begin
                    // widest setting first: full-length name, full copy limit
                    len   = 5'd16;
                    limit = 10'd1023;
                end
                else begin
                    case ($urandom_range(7))
                        0: len = 5'd0;
                        1: len = 5'd1;
                        2: len = 5'($urandom_range(17, 31));
                        default: len = 5'($urandom_range(2, 15));
                    endcase
                    case ($urandom_range(5))
                        0: limit = 10'd0;
                        1: limit = 10'd1;
                        2: limit = 10'($urandom_range(2, 5));
                        3: limit = 10'd1023;
                        default: limit = 10'($urandom_range(6, 1022));
                    endcase
                end
                span = (len > 5'd16) ? 16 : int'(len);
                name_word = {$urandom(), $urandom(), $urandom(), $urandom()};
                for (int i = 0; i < span; i++)
                    name_word[i * 8 +: 8] = rand_text_byte(1'b1);
                apply_settings(len, limit, 1'($urandom_range(1)), name_word);

                phase_bytes = 0;
                while (phase_bytes < BYTES_PER_SETTING) begin
                    hdr.delete();
                    done_early = 1'b0;
                    case ($urandom_range(99)) inside
                        [0:69]: begin
                            // well-formed header with random content
                            repeat ($urandom_range(0, 2)) add_decoy();
                            if ($urandom_range(9) != 0) begin
                                add_name(name_used);
                                // prefix match: the name may run on before the colon
                                if ($urandom_range(4) == 0)
                                    repeat ($urandom_range(1, 3)) hdr.push_back(letter());
                                if ($urandom_range(9) == 0) begin
                                    // no separator after the name: end the text on this line
                                    repeat ($urandom_range(0, 4)) hdr.push_back(letter());
                                    add_eol();
                                    done_early = 1'b1;
                                end
                                else begin
                                    hdr.push_back(CH_COLON);
                                    add_lws();
                                    add_value();
                                    // cut off mid-value now and then
                                    if ($urandom_range(6) == 0)
                                        done_early = 1'b1;
                                    else
                                        add_eol();
                                end
                            end
                            if (!done_early) begin
                                repeat ($urandom_range(0, 1)) add_decoy();
                                case ($urandom_range(4))
                                    0, 1: begin
                                        hdr.push_back(CH_CR);
                                        hdr.push_back(CH_LF);
                                    end
                                    2: begin
                                        // NUL ends the text; the tail is ignored
                                        hdr.push_back(CH_NUL);
                                        repeat ($urandom_range(0, 3))
                                            hdr.push_back(8'($urandom_range(255)));
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        [70:84]: begin
                            // raw noise
                            repeat ($urandom_range(1, 24)) hdr.push_back(8'($urandom_range(255)));
                        end
                        default: begin
                            // broken field: partial name, lone CR, dangling fold
                            add_name($urandom_range(0, name_used));
                            case ($urandom_range(3))
                                0: ;
                                1: begin
                                    hdr.push_back(CH_COLON);
                                    hdr.push_back(CH_CR);
                                    hdr.push_back(letter());
                                end
                                2: begin
                                    hdr.push_back(CH_COLON);
                                    add_lws();
                                end
                                default: begin
                                    hdr.push_back(CH_COLON);
                                    hdr.push_back(CH_CR);
                                    hdr.push_back(CH_LF);
                                    hdr.push_back(letter());
                                end
                            endcase
                        end
                    endcase
                    if (hdr.size() == 0)
                        hdr.push_back(letter());
                    send_header();
                    phase_bytes += hdr.size();
                end
            end
        end

        // Drop valid, wait for the last results, then give stray ones a chance to show
        @(negedge clk);
        text_valid <= 1'b0;
        for (int w = 0; w < 20000 && pending != 0; w++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (pending != 0)
            $error("%0d expected result transactions never arrived", pending);

        $display("Sent %0d header bytes under %0d register settings, checked %0d results",
                 bytes_sent, settings_used, results_checked);
        $display("Lookups closed: %0d found, %0d not found or without colon",
                 lookups_found, lookups_missed);
        if (fail_count == 0 && pending == 0)
            $display("http_header_field_extractor test passed");
        else
            $display("http_header_field_extractor test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("http_header_field_extractor test failed");
        $finish;
    end

endmodule
